FILE: rtl/core/lm_pkg.sv
package lm_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last_item;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] median_doubled;
    logic                        status;
  } out_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // read address source of the store
  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_LO   = 2'd1,
    RD_HI   = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    take;      // input transfer: latch sample, check room
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    shift;     // move read entry up one place
    logic    place;     // write sample at insertion point, count up
    logic    out_load;  // load result register, start a new list
  } cmd_t;

  typedef struct packed {
    logic room;
    logic pos_zero;
    logic gt;
    logic last;
    logic ovf;
  } sts_t;

endpackage

FILE: rtl/core/lm_datapath.sv
module lm_datapath import lm_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [SAMPLE_BITS-1:0] store_q [MAX_ITEMS];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] half_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          last_q;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 pos_q, pos_d;
  logic                          ovf_q, ovf_d;
  out_t                          out_q;

  logic [CW-1:0]                 pos_m1;
  logic [CW-1:0]                 lo_idx;
  logic [CW-1:0]                 hi_idx;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic signed [SAMPLE_BITS:0]   sum;

  assign pos_m1 = pos_q - CW'(1);
  // lower middle is (n-1)/2, upper middle n/2; equal for an odd count
  assign lo_idx = (cnt_q - CW'(1)) >> 1;
  assign hi_idx = cnt_q >> 1;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV: rd_addr = pos_m1[AW-1:0];
      RD_LO:   rd_addr = lo_idx[AW-1:0];
      RD_HI:   rd_addr = hi_idx[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_data = cmd_i.shift ? rd_q : sample_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos_q[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= store_q[rd_addr];
    end
  end

  assign sts_o.room     = ~ovf_q & (cnt_q < CW'(MAX_ITEMS));
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.gt       = (rd_q > sample_q);
  assign sts_o.last     = last_q;
  assign sts_o.ovf      = ovf_q;

  assign sum = {half_q[SAMPLE_BITS-1], half_q} + {rd_q[SAMPLE_BITS-1], rd_q};

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (cmd_i.take) begin
      pos_d = cnt_q;
      ovf_d = ~sts_o.room;
    end
    if (cmd_i.shift) begin
      pos_d = pos_m1;
    end
    if (cmd_i.place) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.take) begin
      sample_q <= in_data_i.sample_value;
      last_q   <= in_data_i.last_item;
    end
    // first median operand arrives the cycle after its read
    if (cmd_i.rd_en && cmd_i.rd_sel == RD_HI) begin
      half_q <= rd_q;
    end
    if (cmd_i.out_load) begin
      if (ovf_q) begin
        out_q.median_doubled <= '0;
        out_q.status         <= STATUS_OVERFLOW;
      end else begin
        out_q.median_doubled <= sum;
        out_q.status         <= STATUS_OK;
      end
    end
  end

  assign out_data_o = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("entry count beyond capacity");

  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.place || cmd_i.shift) |-> (!ovf_q && pos_q <= cnt_q && cnt_q < CW'(MAX_ITEMS)))
    else $error("store written outside the insertion range");

  a_list_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (cnt_q == '0 && !ovf_q))
    else $error("list state not cleared after result");

endmodule

FILE: rtl/core/lm_ctrl.sv
module lm_ctrl import lm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SH_RD  = 3'd1;
  localparam logic [2:0] S_SH_CMP = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_MED_A  = 3'd4;
  localparam logic [2:0] S_MED_B  = 3'd5;
  localparam logic [2:0] S_MED_C  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, rd_sel: RD_PREV};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.room ? S_SH_RD : S_FIN;
        end
      end
      S_SH_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_SH_CMP;
        end
      end
      S_SH_CMP: begin
        if (sts_i.gt) begin
          cmd_o.shift = 1'b1;
          state_d     = S_SH_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.ovf) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MED_A;
        end
      end
      S_MED_A: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LO;
        state_d      = S_MED_B;
      end
      S_MED_B: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_HI;
        state_d      = S_MED_C;
      end
      S_MED_C: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");

  a_result_follows_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q) == S_FIN || $past(state_q) == S_MED_C
      || $past(state_q) == S_OUT)
    else $error("result loaded outside the list end sequence");

  a_take_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> (state_q == S_IDLE && !in_stall_o))
    else $error("input transfer taken while busy");

endmodule

FILE: rtl/core/list_median.sv
// Channel  | Valid       | Stall       | Payload
// ---------+-------------+-------------+--------------------------------------
// input    | in_valid_i  | in_stall_o  | in_data_i  (sample_value, last_item)
// result   | out_valid_o | out_stall_i | out_data_o (median_doubled, status)
//
// An item is taken, then for each stored entry it moves up past, that entry is
// read, compared and written one place up; the item is then placed. A list's last
// item adds two median reads, a settle state and the output. Each move is one
// read and one write. Overflowing items skip the store; a last one goes to output.
// rst_ni clears the count and overflow flag; store contents stay undefined.
// A held result stays put while the next item is taken; a second one waits.
module list_median import lm_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  lm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lm_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
